/* rtl/core/rmq_pkg.sv */
// Shared types and constants for the rotation-matrix-to-quaternion pipeline.
// No dependencies; every other file of the block refers to it by scoped names.
package rmq_pkg;

  localparam int CAND_W      = 19;  // candidate width, signed
  localparam int PAIR_W      = 17;  // off-diagonal pair sum width, signed
  localparam int RAD_W       = 30;  // radicand width, two bits consumed per step
  localparam int ROOT_W      = 15;
  localparam int SQ_REM_W    = 19;
  localparam int SQ_STEPS    = 3;   // root bits per pipeline stage
  localparam int SQ_STAGES   = 5;
  localparam int V_W         = 15;
  localparam int DEN_W       = 16;
  localparam int QUO_W       = 16;
  localparam int DIV_REM_W   = 17;
  localparam int DIV_STEPS   = 4;   // quotient bits per pipeline stage
  localparam int DIV_STAGES  = 4;
  localparam int LANES       = 3;

  localparam logic signed [CAND_W-1:0] CAND_ONE = 19'sd16384;
  localparam logic [QUO_W-1:0] SAT_LIMIT = 16'd16384;

  typedef enum logic [1:0] {
    PICK_X = 2'd0,
    PICK_Y = 2'd1,
    PICK_Z = 2'd2,
    PICK_W = 2'd3
  } pick_t;

  typedef struct packed {
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m13;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [15:0] m23;
    logic signed [15:0] m31;
    logic signed [15:0] m32;
    logic signed [15:0] m33;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               valid_res;
  } rmq_out_t;

  // Travels beside the square root: the pick, its ok flag and the three off-diagonal
  // terms, ordered as the remaining components in ascending x, y, z, w order.
  typedef struct packed {
    pick_t                    big;
    logic                     ok;
    logic signed [PAIR_W-1:0] s0;
    logic signed [PAIR_W-1:0] s1;
    logic signed [PAIR_W-1:0] s2;
  } rmq_side_t;

  // Travels beside the dividers.
  typedef struct packed {
    pick_t            big;
    logic             ok;
    logic [LANES-1:0] neg;
    logic [V_W-1:0]   v;
  } rmq_tag_t;

endpackage

/* rtl/core/rmq_select.sv */
// Candidate formation and largest-candidate pick, two register stages.
// Depends on rmq_pkg.
module rmq_select (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  rmq_pkg::rmq_in_t         matrix,
  output logic                     out_valid,
  output logic [rmq_pkg::RAD_W-1:0] rad,
  output rmq_pkg::rmq_side_t       side
);

  logic                                  valid1;
  logic signed [rmq_pkg::CAND_W-1:0]     cand [4];
  logic signed [rmq_pkg::PAIR_W-1:0]     pa, pb, pc, pd, pe, pf;
  logic signed [rmq_pkg::CAND_W-1:0]     e11, e22, e33;

  assign e11 = rmq_pkg::CAND_W'(matrix.m11);
  assign e22 = rmq_pkg::CAND_W'(matrix.m22);
  assign e33 = rmq_pkg::CAND_W'(matrix.m33);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    cand[0] <= rmq_pkg::CAND_ONE + e11 - e22 - e33;
    cand[1] <= rmq_pkg::CAND_ONE - e11 + e22 - e33;
    cand[2] <= rmq_pkg::CAND_ONE - e11 - e22 + e33;
    cand[3] <= rmq_pkg::CAND_ONE + e11 + e22 + e33;
    pa <= rmq_pkg::PAIR_W'(matrix.m12) + rmq_pkg::PAIR_W'(matrix.m21);
    pb <= rmq_pkg::PAIR_W'(matrix.m31) + rmq_pkg::PAIR_W'(matrix.m13);
    pc <= rmq_pkg::PAIR_W'(matrix.m23) - rmq_pkg::PAIR_W'(matrix.m32);
    pd <= rmq_pkg::PAIR_W'(matrix.m23) + rmq_pkg::PAIR_W'(matrix.m32);
    pe <= rmq_pkg::PAIR_W'(matrix.m31) - rmq_pkg::PAIR_W'(matrix.m13);
    pf <= rmq_pkg::PAIR_W'(matrix.m12) - rmq_pkg::PAIR_W'(matrix.m21);
  end

  rmq_pkg::pick_t                    big;
  logic signed [rmq_pkg::CAND_W-1:0] best;
  rmq_pkg::rmq_side_t                side_next;

  // Strict compares keep the lowest index on a tie.
  always_comb begin
    big  = rmq_pkg::PICK_X;
    best = cand[0];
    if (cand[1] > best) begin
      big  = rmq_pkg::PICK_Y;
      best = cand[1];
    end
    if (cand[2] > best) begin
      big  = rmq_pkg::PICK_Z;
      best = cand[2];
    end
    if (cand[3] > best) begin
      big  = rmq_pkg::PICK_W;
      best = cand[3];
    end
    side_next.big = big;
    side_next.ok  = ~best[rmq_pkg::CAND_W-1];
    case (big)
      rmq_pkg::PICK_X: begin
        side_next.s0 = pa;
        side_next.s1 = pb;
        side_next.s2 = pc;
      end
      rmq_pkg::PICK_Y: begin
        side_next.s0 = pa;
        side_next.s1 = pd;
        side_next.s2 = pe;
      end
      rmq_pkg::PICK_Z: begin
        side_next.s0 = pb;
        side_next.s1 = pd;
        side_next.s2 = pf;
      end
      default: begin
        side_next.s0 = pc;
        side_next.s1 = pe;
        side_next.s2 = pf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid1;
    end
    rad  <= {1'b0, best[16:0], 12'b0};
    side <= side_next;
  end

endmodule

/* rtl/core/rmq_sqrt.sv */
// Pipelined digit-by-digit integer square root, a few root bits per stage.
// Depends on rmq_pkg.
module rmq_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [rmq_pkg::RAD_W-1:0]    rad,
  input  rmq_pkg::rmq_side_t           side_in,
  output logic                         out_valid,
  output logic [rmq_pkg::ROOT_W-1:0]   root,
  output logic [rmq_pkg::SQ_REM_W-1:0] rem,
  output rmq_pkg::rmq_side_t           side_out
);

  localparam int N = rmq_pkg::SQ_STAGES;

  logic                         st_valid [N+1];
  logic [rmq_pkg::RAD_W-1:0]    st_rad   [N+1];
  logic [rmq_pkg::ROOT_W-1:0]   st_root  [N+1];
  logic [rmq_pkg::SQ_REM_W-1:0] st_rem   [N+1];
  rmq_pkg::rmq_side_t           st_side  [N+1];

  assign st_valid[0] = in_valid;
  assign st_rad[0]   = rad;
  assign st_root[0]  = '0;
  assign st_rem[0]   = '0;
  assign st_side[0]  = side_in;

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [rmq_pkg::RAD_W-1:0]    w_rad;
    logic [rmq_pkg::ROOT_W-1:0]   w_root;
    logic [rmq_pkg::SQ_REM_W-1:0] w_rem;
    logic [rmq_pkg::SQ_REM_W-1:0] t;
    logic [rmq_pkg::SQ_REM_W-1:0] trial;

    always_comb begin
      w_rad  = st_rad[g];
      w_root = st_root[g];
      w_rem  = st_rem[g];
      t      = '0;
      trial  = '0;
      for (int k = 0; k < rmq_pkg::SQ_STEPS; k++) begin
        t     = {w_rem[rmq_pkg::SQ_REM_W-3:0], w_rad[rmq_pkg::RAD_W-1 -: 2]};
        trial = {2'b00, w_root, 2'b01};
        if (t >= trial) begin
          w_rem  = t - trial;
          w_root = {w_root[rmq_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          w_rem  = t;
          w_root = {w_root[rmq_pkg::ROOT_W-2:0], 1'b0};
        end
        w_rad = {w_rad[rmq_pkg::RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[g+1] <= 1'b0;
      end else begin
        st_valid[g+1] <= st_valid[g];
      end
      st_rad[g+1]  <= w_rad;
      st_root[g+1] <= w_root;
      st_rem[g+1]  <= w_rem;
      st_side[g+1] <= st_side[g];
    end
  end

  assign out_valid = st_valid[N];
  assign root      = st_root[N];
  assign rem       = st_rem[N];
  assign side_out  = st_side[N];

endmodule

/* rtl/core/rmq_div.sv */
// Root rounding, three pipelined long dividers sharing one divisor, and the
// saturating output stage. Depends on rmq_pkg.
module rmq_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [rmq_pkg::ROOT_W-1:0]   root,
  input  logic [rmq_pkg::SQ_REM_W-1:0] rem,
  input  rmq_pkg::rmq_side_t           side,
  output logic                         done,
  output rmq_pkg::rmq_out_t            result
);

  localparam int N = rmq_pkg::DIV_STAGES;
  localparam int L = rmq_pkg::LANES;

  logic                          st_valid [N+1];
  logic [rmq_pkg::DEN_W-1:0]     st_den   [N+1];
  logic [rmq_pkg::QUO_W-1:0]     st_num   [N+1][L];
  logic [rmq_pkg::DIV_REM_W-1:0] st_rem   [N+1][L];
  logic [rmq_pkg::QUO_W-1:0]     st_quo   [N+1][L];
  rmq_pkg::rmq_tag_t             st_tag   [N+1];

  // Round the root to nearest, then build numerator 8192*|s| + v over 2v.
  logic [rmq_pkg::V_W-1:0]    v;
  logic signed [rmq_pkg::PAIR_W-1:0] s [L];
  logic [L-1:0]               neg;
  logic [rmq_pkg::RAD_W-1:0]  numer [L];

  assign v    = root + rmq_pkg::V_W'(rem > rmq_pkg::SQ_REM_W'(root));
  assign s[0] = side.s0;
  assign s[1] = side.s1;
  assign s[2] = side.s2;

  for (genvar i = 0; i < L; i++) begin : g_num
    logic signed [rmq_pkg::PAIR_W:0] ext;
    logic [rmq_pkg::PAIR_W-1:0]      mag;
    assign ext      = -{s[i][rmq_pkg::PAIR_W-1], s[i]};
    assign neg[i]   = s[i][rmq_pkg::PAIR_W-1];
    assign mag      = neg[i] ? ext[rmq_pkg::PAIR_W-1:0] : s[i];
    assign numer[i] = {mag, 13'b0} + rmq_pkg::RAD_W'(v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else begin
      st_valid[0] <= in_valid;
    end
    st_den[0]     <= {v, 1'b0};
    st_tag[0].big <= side.big;
    st_tag[0].ok  <= side.ok;
    st_tag[0].neg <= neg;
    st_tag[0].v   <= v;
    for (int i = 0; i < L; i++) begin
      // The quotient stays below 2^16, so the top bits form the first remainder.
      st_rem[0][i] <= {3'b000, numer[i][rmq_pkg::RAD_W-1:rmq_pkg::QUO_W]};
      st_num[0][i] <= numer[i][rmq_pkg::QUO_W-1:0];
      st_quo[0][i] <= '0;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    for (genvar i = 0; i < L; i++) begin : g_lane
      logic [rmq_pkg::QUO_W-1:0]     w_num;
      logic [rmq_pkg::DIV_REM_W-1:0] w_rem;
      logic [rmq_pkg::QUO_W-1:0]     w_quo;
      logic [rmq_pkg::DIV_REM_W-1:0] t;
      logic [rmq_pkg::DIV_REM_W-1:0] d;

      always_comb begin
        w_num = st_num[g][i];
        w_rem = st_rem[g][i];
        w_quo = st_quo[g][i];
        d     = {1'b0, st_den[g]};
        t     = '0;
        for (int k = 0; k < rmq_pkg::DIV_STEPS; k++) begin
          t = {w_rem[rmq_pkg::DIV_REM_W-2:0], w_num[rmq_pkg::QUO_W-1]};
          if (t >= d) begin
            w_rem = t - d;
            w_quo = {w_quo[rmq_pkg::QUO_W-2:0], 1'b1};
          end else begin
            w_rem = t;
            w_quo = {w_quo[rmq_pkg::QUO_W-2:0], 1'b0};
          end
          w_num = {w_num[rmq_pkg::QUO_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        st_num[g+1][i] <= w_num;
        st_rem[g+1][i] <= w_rem;
        st_quo[g+1][i] <= w_quo;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[g+1] <= 1'b0;
      end else begin
        st_valid[g+1] <= st_valid[g];
      end
      st_den[g+1] <= st_den[g];
      st_tag[g+1] <= st_tag[g];
    end
  end

  // Saturate, apply signs and place the three quotients around the pick.
  logic signed [15:0]  comp [L];
  logic signed [15:0]  vsat;
  rmq_pkg::rmq_tag_t   tag;
  rmq_pkg::rmq_out_t   result_next;

  assign tag  = st_tag[N];
  assign vsat = (16'(tag.v) > rmq_pkg::SAT_LIMIT) ? rmq_pkg::SAT_LIMIT : 16'(tag.v);

  for (genvar i = 0; i < L; i++) begin : g_sat
    logic [15:0] mag;
    assign mag     = (st_quo[N][i] > rmq_pkg::SAT_LIMIT) ? rmq_pkg::SAT_LIMIT : st_quo[N][i];
    assign comp[i] = tag.neg[i] ? -$signed(mag) : $signed(mag);
  end

  always_comb begin
    result_next = '0;
    if (tag.ok) begin
      result_next.valid_res = 1'b1;
      case (tag.big)
        rmq_pkg::PICK_X: begin
          result_next.quat_x = vsat;
          result_next.quat_y = comp[0];
          result_next.quat_z = comp[1];
          result_next.quat_w = comp[2];
        end
        rmq_pkg::PICK_Y: begin
          result_next.quat_x = comp[0];
          result_next.quat_y = vsat;
          result_next.quat_z = comp[1];
          result_next.quat_w = comp[2];
        end
        rmq_pkg::PICK_Z: begin
          result_next.quat_x = comp[0];
          result_next.quat_y = comp[1];
          result_next.quat_z = vsat;
          result_next.quat_w = comp[2];
        end
        default: begin
          result_next.quat_x = comp[0];
          result_next.quat_y = comp[1];
          result_next.quat_z = comp[2];
          result_next.quat_w = vsat;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= st_valid[N];
    end
    result <= result_next;
  end

endmodule

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Rotation matrix (Q1.14) to quaternion (Q1.14) by Shepperd's method, fully
// pipelined: one matrix may start in every cycle and busy never rises. Each
// transaction's result appears on result for one cycle, marked by done; the
// receiver cannot stall it. The pipeline holds two selection stages, a 5-stage
// square root (3 root bits per stage), a rounding stage, a 4-stage divider
// (4 quotient bits per stage) and the output register. Depends on rmq_pkg,
// rmq_select, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rmq_pkg::rmq_in_t  matrix,
  output logic              done,
  output rmq_pkg::rmq_out_t result
);

  logic                         sel_valid;
  logic [rmq_pkg::RAD_W-1:0]    sel_rad;
  rmq_pkg::rmq_side_t           sel_side;
  logic                         sq_valid;
  logic [rmq_pkg::ROOT_W-1:0]   sq_root;
  logic [rmq_pkg::SQ_REM_W-1:0] sq_rem;
  rmq_pkg::rmq_side_t           sq_side;

  assign busy = 1'b0;

  rmq_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .matrix    (matrix),
    .out_valid (sel_valid),
    .rad       (sel_rad),
    .side      (sel_side)
  );

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .rad       (sel_rad),
    .side_in   (sel_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .rem       (sq_rem),
    .side_out  (sq_side)
  );

  rmq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .root     (sq_root),
    .rem      (sq_rem),
    .side     (sq_side),
    .done     (done),
    .result   (result)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for rotation_matrix_to_quaternion.
// Depends on rmq_pkg and the block's RTL; predicts each quaternion independently.
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = 13;

  class quat_scoreboard;
    rmq_pkg::rmq_out_t pending[$];
    int errors = 0;

    function automatic int unsigned root_round(int unsigned x);
      int unsigned r;
      int unsigned b;
      r = 0;
      b = 32'h4000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      if (x > r) r++;
      return r;
    endfunction

    function automatic logic signed [15:0] clip(int x);
      if (x > 16384) return 16'sd16384;
      if (x < -16384) return -16'sd16384;
      return x[15:0];
    endfunction

    function automatic logic signed [15:0] ratio(int s, int unsigned v);
      int unsigned mag;
      int q;
      mag = (s < 0) ? -s : s;
      q = int'((mag * 8192 + v) / (2 * v));
      return clip(s < 0 ? -q : q);
    endfunction

    function automatic rmq_pkg::rmq_out_t convert(rmq_pkg::rmq_in_t m);
      int c[4];
      int a11, a12, a13, a21, a22, a23, a31, a32, a33;
      rmq_pkg::pick_t big;
      int unsigned v;
      logic signed [15:0] q[4];
      rmq_pkg::rmq_out_t r;
      a11 = m.m11; a12 = m.m12; a13 = m.m13;
      a21 = m.m21; a22 = m.m22; a23 = m.m23;
      a31 = m.m31; a32 = m.m32; a33 = m.m33;
      c[0] = 16384 + a11 - a22 - a33;
      c[1] = 16384 - a11 + a22 - a33;
      c[2] = 16384 - a11 - a22 + a33;
      c[3] = 16384 + a11 + a22 + a33;
      big = rmq_pkg::PICK_X;
      for (int i = 1; i < 4; i++) if (c[i] > c[big]) big = rmq_pkg::pick_t'(i);
      for (int i = 0; i < 4; i++) q[i] = '0;
      r.valid_res = c[big] >= 0;
      if (r.valid_res) begin
        v = root_round(c[big] * 4096);
        if (v == 0) v = 1;
        q[big] = clip(int'(v));
        case (big)
          rmq_pkg::PICK_X: begin
            q[1] = ratio(a12 + a21, v); q[2] = ratio(a31 + a13, v);
            q[3] = ratio(a23 - a32, v);
          end
          rmq_pkg::PICK_Y: begin
            q[0] = ratio(a12 + a21, v); q[2] = ratio(a23 + a32, v);
            q[3] = ratio(a31 - a13, v);
          end
          rmq_pkg::PICK_Z: begin
            q[0] = ratio(a31 + a13, v); q[1] = ratio(a23 + a32, v);
            q[3] = ratio(a12 - a21, v);
          end
          default: begin
            q[0] = ratio(a23 - a32, v); q[1] = ratio(a31 - a13, v);
            q[2] = ratio(a12 - a21, v);
          end
        endcase
      end
      r.quat_x = q[0]; r.quat_y = q[1]; r.quat_z = q[2]; r.quat_w = q[3];
      return r;
    endfunction

    function void note_matrix(rmq_pkg::rmq_in_t m);
      pending.push_back(convert(m));
    endfunction

    function void check_quat(rmq_pkg::rmq_out_t got);
      rmq_pkg::rmq_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected x=%0d y=%0d z=%0d w=%0d v=%0b, ",
                    "got x=%0d y=%0d z=%0d w=%0d v=%0b"},
                   want.quat_x, want.quat_y, want.quat_z, want.quat_w, want.valid_res,
                   got.quat_x, got.quat_y, got.quat_z, got.quat_w, got.valid_res);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  rmq_pkg::rmq_in_t matrix = '0;
  rmq_pkg::rmq_out_t result;
  quat_scoreboard board = new();

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .matrix(matrix), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_quat(result);
      if (start && !busy) board.note_matrix(matrix);
    end
  end

  function automatic logic signed [15:0] pick_elem(int mode);
    case (mode)
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd16384;
      3: return -16'sd16384;
      4: return '0;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Drives one transaction; start stays high across back-to-back items.
  task automatic send_matrix(rmq_pkg::rmq_in_t m, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    matrix <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random matrix with every element between minus one and plus one.
  function automatic rmq_pkg::rmq_in_t near_rotation();
    rmq_pkg::rmq_in_t m;
    m = '0;
    m.m11 = 16'($urandom_range(0, 32768) - 16384);
    m.m22 = 16'($urandom_range(0, 32768) - 16384);
    m.m33 = 16'($urandom_range(0, 32768) - 16384);
    m.m12 = 16'($urandom_range(0, 32768) - 16384);
    m.m21 = 16'($urandom_range(0, 32768) - 16384);
    m.m13 = 16'($urandom_range(0, 32768) - 16384);
    m.m31 = 16'($urandom_range(0, 32768) - 16384);
    m.m23 = 16'($urandom_range(0, 32768) - 16384);
    m.m32 = 16'($urandom_range(0, 32768) - 16384);
    return m;
  endfunction

  initial begin
    rmq_pkg::rmq_in_t m;
    int gap;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: identity, the three half-turns, ties, and extremes.
    m = '0; m.m11 = 16384; m.m22 = 16384; m.m33 = 16384; send_matrix(m, 0);
    m = '0; m.m11 = 16384; m.m22 = -16384; m.m33 = -16384; send_matrix(m, 0);
    m = '0; m.m11 = -16384; m.m22 = 16384; m.m33 = -16384; send_matrix(m, 1);
    m = '0; m.m11 = -16384; m.m22 = -16384; m.m33 = 16384; send_matrix(m, 0);
    m = '0; send_matrix(m, 0);
    m = {9{16'sh8000}}; send_matrix(m, 2);
    m = {9{16'sh7fff}}; send_matrix(m, 0);
    m = {9{16'hffff}}; send_matrix(m, 0);
    m = '0; m.m11 = 16'sh8000; m.m22 = 16'sh8000; m.m33 = 16'sh8000;
    m.m12 = 16'sh7fff; m.m21 = 16'sh7fff; m.m23 = 16'sh8000; m.m32 = 16'sh7fff;
    send_matrix(m, 0);
    m = '0; m.m11 = 16'sh7fff; m.m22 = 16'sh8000; m.m33 = 16'sh8000;
    m.m12 = 16'sh7fff; m.m21 = 16'sh7fff; m.m13 = 16'sh8000; m.m31 = 16'sh8000;
    send_matrix(m, 0);
    m = '0; m.m33 = 16'sh7fff; m.m11 = 16'sh8000; m.m22 = 16'sh8000;
    m.m23 = 16'sh7fff; m.m32 = 16'sh7fff; send_matrix(m, 3);
    m = '0; m.m11 = 5461; m.m22 = 5461; m.m33 = 5461; send_matrix(m, 0);
    for (int i = 0; i < 10; i++) begin
      for (int k = 0; k < 9; k++) m[k*16 +: 16] = pick_elem($urandom_range(0, 5));
      send_matrix(m, 0);
    end
    // Random: mostly elements within plus or minus one, some raw bit patterns, random idle gaps.
    for (int i = 0; i < 800; i++) begin
      if ($urandom_range(0, 9) < 7) m = near_rotation();
      else for (int k = 0; k < 9; k++) m[k*16 +: 16] = pick_elem($urandom_range(0, 9));
      gap = $urandom_range(0, 9);
      send_matrix(m, gap);
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (board.errors == 0) $display("[rotation_matrix_to_quaternion] OK");
    else $display("[rotation_matrix_to_quaternion] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[rotation_matrix_to_quaternion] ERROR");
    $finish;
  end
endmodule
